// ===== rtl/pie_pkg.sv =====
// Package: widths, limits, mode codes, status codes and register indices of the PageRank iteration engine.
`default_nettype none
package pie_pkg;
  localparam int unsigned MaxNodes     = 1024;
  localparam int unsigned MaxEdges     = 8192;
  localparam int unsigned RankFracBits = 32;

  localparam int unsigned NodeW  = 10;
  localparam int unsigned CountW = 11;
  localparam int unsigned EdgeAw = 13;
  localparam int unsigned EcntW  = 14;
  localparam int unsigned DegW   = 14;
  localparam int unsigned RankW  = 32;
  localparam int unsigned AccW   = 33;
  localparam int unsigned SumW   = 42;
  localparam int unsigned NumW   = 65;
  localparam int unsigned IterW  = 8;
  localparam int unsigned CfgW   = 11;

  localparam logic [1:0] ModeLoad  = 2'd0;
  localparam logic [1:0] ModeRun   = 2'd1;
  localparam logic [1:0] ModeRead  = 2'd2;
  localparam logic [1:0] ModeClear = 2'd3;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusFull  = 2'd1;
  localparam logic [1:0] StatusRange = 2'd2;

  localparam logic CfgIterations = 1'b0;
  localparam logic CfgNodeCount  = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/pie_div.sv =====
// Restoring divider: one quotient bit per cycle, shared by all divisions of the engine.
`default_nettype none
module pie_div
  import pie_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [SumW-1:0] den_i,
  output logic                 done_o,
  output logic [NumW-1:0]      quot_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [SumW:0]   rem_q, rem_d, trial;
  logic [NumW-1:0] quo_q, quo_d;
  logic [SumW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic            ge;

  always_comb begin
    trial  = {rem_q[SumW-1:0], quo_q[NumW-1]};
    ge     = trial >= {1'b0, den_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? (trial - {1'b0, den_q}) : trial;
      quo_d = {quo_q[NumW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(NumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
endmodule
`default_nettype wire

// ===== rtl/pagerank_iteration_engine.sv =====
// Top level: PageRank power-iteration engine with edge, degree, rank and accumulator memories.
`default_nettype none
// Edge loads, reads, run and clear commands each return one result. After reset, and on a clear
// command, a sweep over all 1024 addresses zeroes the degree memory (after reset also ranks and
// accumulators); no request is taken meanwhile. A run divides to get the start rank 1/N and
// the floor 1/N^2, initializes ranks and accumulators, then per iteration adds each valid edge's
// rank share over the source degree, sums the clamped accumulators and divides each one by the
// sum: the single divider, which yields all 65 quotient bits in turn, serves every division.
module pagerank_iteration_engine
  import pie_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        mode_i,
  input  wire logic [NodeW-1:0]  src_node_i,
  input  wire logic [NodeW-1:0]  dst_node_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [1:0]             status_o,
  output logic [NodeW-1:0]       node_o,
  output logic [RankW-1:0]       rank_value_o,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [CfgW-1:0]   cfg_data_i
);
  localparam logic [4:0] StClr    = 5'd0;
  localparam logic [4:0] StIdle   = 5'd1;
  localparam logic [4:0] StLdW    = 5'd2;
  localparam logic [4:0] StRdR    = 5'd3;
  localparam logic [4:0] StROne   = 5'd4;
  localparam logic [4:0] StROneW  = 5'd5;
  localparam logic [4:0] StRLo    = 5'd6;
  localparam logic [4:0] StRLoW   = 5'd7;
  localparam logic [4:0] StRInit  = 5'd8;
  localparam logic [4:0] StIter   = 5'd9;
  localparam logic [4:0] StEFetch = 5'd10;
  localparam logic [4:0] StERd    = 5'd11;
  localparam logic [4:0] StEChk   = 5'd12;
  localparam logic [4:0] StEDiv   = 5'd13;
  localparam logic [4:0] StSAddr  = 5'd14;
  localparam logic [4:0] StSAcc   = 5'd15;
  localparam logic [4:0] StNAddr  = 5'd16;
  localparam logic [4:0] StNDiv   = 5'd17;
  localparam logic [4:0] StNWait  = 5'd18;

  localparam logic [AccW-1:0] AccMax  = {AccW{1'b1}};
  localparam logic [RankW:0]  OneFx   = {1'b1, {RankW{1'b0}}};

  logic [EdgeAw*0+2*NodeW-1:0] edge_mem [MaxEdges];
  logic [DegW-1:0]  deg_mem  [MaxNodes];
  logic [RankW-1:0] rank_mem [MaxNodes];
  logic [AccW-1:0]  nxt_mem  [MaxNodes];

  logic [2*NodeW-1:0] edge_rd;
  logic [DegW-1:0]    deg_rd;
  logic [RankW-1:0]   rank_rd;
  logic [AccW-1:0]    nxt_rd;

  logic [4:0]        state_q, state_d;
  logic              clr_all_q, clr_all_d;
  logic [IterW-1:0]  iter_cfg_q;
  logic [CountW-1:0] ncnt_cfg_q;
  logic [EcntW-1:0]  ecnt_q, ecnt_d;
  logic [EcntW-1:0]  e_q, e_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [IterW-1:0]  it_q, it_d;
  logic [NodeW-1:0]  src_q, src_d, s_q, s_d, d_q, d_d;
  logic [RankW-1:0]  start_q, start_d, lo_q, lo_d;
  logic [AccW-1:0]   acc_q, acc_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        status_q, status_d;
  logic [NodeW-1:0]  node_q, node_d;
  logic [RankW-1:0]  rval_q, rval_d;

  logic [CountW-1:0] n_eff;
  logic [RankW-1:0]  hi;
  logic [RankW-1:0]  clamped;
  logic [AccW:0]     acc_sum;
  logic [2*CountW-1:0] n_sq;
  logic              accept;

  logic              div_start, div_done;
  logic [NumW-1:0]   div_num, div_quot;
  logic [SumW-1:0]   div_den;

  logic                  edge_we, deg_we, rank_we, nxt_we;
  logic [EdgeAw-1:0]     edge_wa, edge_ra;
  logic [NodeW-1:0]      deg_wa, rank_wa, nxt_wa, deg_ra, rank_ra, nxt_ra;
  logic [2*NodeW-1:0]    edge_wd;
  logic [DegW-1:0]       deg_wd;
  logic [RankW-1:0]      rank_wd;
  logic [AccW-1:0]       nxt_wd;

  pie_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    if (ncnt_cfg_q < CountW'(2)) begin
      n_eff = CountW'(2);
    end else if (ncnt_cfg_q > CountW'(MaxNodes)) begin
      n_eff = CountW'(MaxNodes);
    end else begin
      n_eff = ncnt_cfg_q;
    end
    n_sq    = n_eff * n_eff;
    hi      = RankW'(OneFx - {1'b0, lo_q});
    if (nxt_rd < {1'b0, lo_q}) begin
      clamped = lo_q;
    end else if (nxt_rd > {1'b0, hi}) begin
      clamped = hi;
    end else begin
      clamped = nxt_rd[RankW-1:0];
    end
    acc_sum = {1'b0, acc_q} + {1'b0, div_quot[AccW-1:0]};
  end

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle) || out_valid_q;

  always_comb begin
    state_d     = state_q;
    clr_all_d   = clr_all_q;
    ecnt_d      = ecnt_q;
    e_d         = e_q;
    cnt_d       = cnt_q;
    it_d        = it_q;
    src_d       = src_q;
    s_d         = s_q;
    d_d         = d_q;
    start_d     = start_q;
    lo_d        = lo_q;
    acc_d       = acc_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    node_d      = node_q;
    rval_d      = rval_q;

    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;

    edge_we = 1'b0; edge_wa = ecnt_q[EdgeAw-1:0]; edge_wd = {src_node_i, dst_node_i};
    edge_ra = e_q[EdgeAw-1:0];
    deg_we  = 1'b0; deg_wa = cnt_q[NodeW-1:0]; deg_wd = '0;
    rank_we = 1'b0; rank_wa = cnt_q[NodeW-1:0]; rank_wd = '0;
    nxt_we  = 1'b0; nxt_wa = cnt_q[NodeW-1:0]; nxt_wd = '0;
    deg_ra  = src_node_i;
    rank_ra = src_node_i;
    nxt_ra  = cnt_q[NodeW-1:0];

    unique case (state_q)
      StClr: begin
        deg_we = 1'b1;
        if (clr_all_q) begin
          rank_we = 1'b1;
          nxt_we  = 1'b1;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CountW'(MaxNodes - 1)) begin
          state_d = StIdle;
          if (!clr_all_q) begin
            out_valid_d = 1'b1;
            status_d    = StatusOk;
            node_d      = src_q;
            rval_d      = '0;
          end
          clr_all_d = 1'b0;
        end
      end
      StIdle: begin
        if (accept) begin
          src_d = src_node_i;
          unique case (mode_i)
            ModeLoad: begin
              if ({1'b0, src_node_i} >= n_eff || {1'b0, dst_node_i} >= n_eff) begin
                out_valid_d = 1'b1;
                status_d    = StatusRange;
                node_d      = src_node_i;
                rval_d      = '0;
              end else if (ecnt_q >= EcntW'(MaxEdges)) begin
                out_valid_d = 1'b1;
                status_d    = StatusFull;
                node_d      = src_node_i;
                rval_d      = '0;
              end else begin
                edge_we = 1'b1;
                ecnt_d  = ecnt_q + 1'b1;
                state_d = StLdW;
              end
            end
            ModeRun:  state_d = StROne;
            ModeRead: state_d = StRdR;
            ModeClear: begin
              ecnt_d    = '0;
              cnt_d     = '0;
              clr_all_d = 1'b0;
              state_d   = StClr;
            end
            default: state_d = StIdle;
          endcase
        end
      end
      StLdW: begin
        deg_we      = 1'b1;
        deg_wa      = src_q;
        deg_wd      = deg_rd + 1'b1;
        out_valid_d = 1'b1;
        status_d    = StatusOk;
        node_d      = src_q;
        rval_d      = '0;
        state_d     = StIdle;
      end
      StRdR: begin
        out_valid_d = 1'b1;
        node_d      = src_q;
        if ({1'b0, src_q} >= n_eff) begin
          status_d = StatusRange;
          rval_d   = '0;
        end else begin
          status_d = StatusOk;
          rval_d   = rank_rd;
        end
        state_d = StIdle;
      end
      StROne: begin
        div_start = 1'b1;
        div_num   = NumW'(OneFx);
        div_den   = SumW'(n_eff);
        state_d   = StROneW;
      end
      StROneW: begin
        if (div_done) begin
          start_d = div_quot[RankW-1:0];
          state_d = StRLo;
        end
      end
      StRLo: begin
        div_start = 1'b1;
        div_num   = NumW'(OneFx);
        div_den   = SumW'(n_sq);
        state_d   = StRLoW;
      end
      StRLoW: begin
        if (div_done) begin
          lo_d    = (div_quot == '0) ? RankW'(1) : div_quot[RankW-1:0];
          cnt_d   = '0;
          state_d = StRInit;
        end
      end
      StRInit: begin
        rank_we = 1'b1;
        rank_wd = (cnt_q < n_eff) ? start_q : '0;
        nxt_we  = 1'b1;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CountW'(MaxNodes - 1)) begin
          it_d    = '0;
          state_d = StIter;
        end
      end
      StIter: begin
        if (it_q == iter_cfg_q) begin
          out_valid_d = 1'b1;
          status_d    = StatusOk;
          node_d      = src_q;
          rval_d      = '0;
          state_d     = StIdle;
        end else begin
          e_d     = '0;
          cnt_d   = '0;
          sum_d   = '0;
          state_d = StEFetch;
        end
      end
      StEFetch: begin
        if (e_q == ecnt_q) begin
          cnt_d   = '0;
          state_d = StSAddr;
        end else begin
          state_d = StERd;
        end
      end
      StERd: begin
        s_d     = edge_rd[2*NodeW-1:NodeW];
        d_d     = edge_rd[NodeW-1:0];
        deg_ra  = edge_rd[2*NodeW-1:NodeW];
        rank_ra = edge_rd[2*NodeW-1:NodeW];
        nxt_ra  = edge_rd[NodeW-1:0];
        state_d = StEChk;
      end
      StEChk: begin
        if ({1'b0, s_q} >= n_eff || {1'b0, d_q} >= n_eff || deg_rd == '0) begin
          e_d     = e_q + 1'b1;
          state_d = StEFetch;
        end else begin
          acc_d     = nxt_rd;
          div_start = 1'b1;
          div_num   = NumW'(rank_rd);
          div_den   = SumW'(deg_rd);
          state_d   = StEDiv;
        end
      end
      StEDiv: begin
        if (div_done) begin
          nxt_we  = 1'b1;
          nxt_wa  = d_q;
          nxt_wd  = acc_sum[AccW] ? AccMax : acc_sum[AccW-1:0];
          e_d     = e_q + 1'b1;
          state_d = StEFetch;
        end
      end
      StSAddr: begin
        if (cnt_q == n_eff) begin
          cnt_d   = '0;
          state_d = StNAddr;
        end else begin
          state_d = StSAcc;
        end
      end
      StSAcc: begin
        sum_d   = sum_q + SumW'(clamped);
        cnt_d   = cnt_q + 1'b1;
        state_d = StSAddr;
      end
      StNAddr: begin
        if (cnt_q == n_eff) begin
          it_d    = it_q + 1'b1;
          state_d = StIter;
        end else begin
          state_d = StNDiv;
        end
      end
      StNDiv: begin
        div_start = 1'b1;
        div_num   = {1'b0, clamped, {RankFracBits{1'b0}}};
        div_den   = sum_q;
        state_d   = StNWait;
      end
      StNWait: begin
        if (div_done) begin
          rank_we = 1'b1;
          rank_wd = (div_quot[NumW-1:RankW] != '0) ? {RankW{1'b1}} : div_quot[RankW-1:0];
          nxt_we  = 1'b1;
          cnt_d   = cnt_q + 1'b1;
          state_d = StNAddr;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClr;
      clr_all_q   <= 1'b1;
      iter_cfg_q  <= IterW'(100);
      ncnt_cfg_q  <= CountW'(MaxNodes);
      ecnt_q      <= '0;
      e_q         <= '0;
      cnt_q       <= '0;
      it_q        <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_all_q   <= clr_all_d;
      ecnt_q      <= ecnt_d;
      e_q         <= e_d;
      cnt_q       <= cnt_d;
      it_q        <= it_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgIterations) begin
          iter_cfg_q <= cfg_data_i[IterW-1:0];
        end else begin
          ncnt_cfg_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    src_q    <= src_d;
    s_q      <= s_d;
    d_q      <= d_d;
    start_q  <= start_d;
    lo_q     <= lo_d;
    acc_q    <= acc_d;
    status_q <= status_d;
    node_q   <= node_d;
    rval_q   <= rval_d;
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[edge_wa] <= edge_wd;
    end
    edge_rd <= edge_mem[edge_ra];
  end

  always_ff @(posedge clk_i) begin
    if (deg_we) begin
      deg_mem[deg_wa] <= deg_wd;
    end
    deg_rd <= deg_mem[deg_ra];
  end

  always_ff @(posedge clk_i) begin
    if (rank_we) begin
      rank_mem[rank_wa] <= rank_wd;
    end
    rank_rd <= rank_mem[rank_ra];
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    nxt_rd <= nxt_mem[nxt_ra];
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign node_o       = node_q;
  assign rank_value_o = rval_q;
endmodule
`default_nettype wire

// ===== rtl/pie_checker.sv =====
// Port checker for the PageRank iteration engine, bound to the top level.
`default_nettype none
module pie_checker
  import pie_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [1:0]        status_o,
  input wire logic [NodeW-1:0]  node_o,
  input wire logic [RankW-1:0]  rank_value_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(node_o)
      && $stable(rank_value_o))
    else $error("stalled result changed");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("undefined status code");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StatusOk |-> rank_value_o == '0)
    else $error("rank value on failed request");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o || $past(out_valid_o) == 1'b0)
    else $error("request taken while result pending");
endmodule

bind pagerank_iteration_engine pie_checker u_pie_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .node_o       (node_o),
  .rank_value_o (rank_value_o)
);
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench: directed table and random requests for the PageRank iteration engine, with a predictor.
`timescale 1ns / 1ps
module tb;
  import pie_pkg::*;

  localparam int unsigned CycleLimit = 20000000;
  localparam int unsigned RunCap     = 8000;
  localparam int unsigned SplitRow   = 2;
  localparam logic [32:0] AccMax     = 33'h1_FFFF_FFFF;

  typedef struct {
    logic [1:0]       status;
    logic [NodeW-1:0] node;
    logic [RankW-1:0] rank_value;
  } rank_result_t;

  typedef struct {
    logic [1:0]       mode;
    logic [NodeW-1:0] src;
    logic [NodeW-1:0] dst;
    bit               typed;
    logic [1:0]       status;
    logic [RankW-1:0] rank_value;
  } req_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] mode_i = ModeRead;
  logic [NodeW-1:0] src_node_i = '0;
  logic [NodeW-1:0] dst_node_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] status_o;
  logic [NodeW-1:0] node_o;
  logic [RankW-1:0] rank_value_o;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = CfgIterations;
  logic [CfgW-1:0] cfg_data_i = '0;

  pagerank_iteration_engine dut (.*);

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [IterW-1:0]  pr_iters = 8'd100;
  logic [CountW-1:0] pr_count = 11'd1024;
  logic [NodeW-1:0]  pr_esrc [MaxEdges];
  logic [NodeW-1:0]  pr_edst [MaxEdges];
  int unsigned       pr_ecnt = 0;
  logic [DegW-1:0]   pr_deg  [MaxNodes];
  logic [RankW-1:0]  pr_rank [MaxNodes];
  logic [AccW-1:0]   pr_acc  [MaxNodes];

  rank_result_t rank_expect_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit quiet = 1'b0;
  int unsigned stall_left = 0;

  initial begin
    for (int i = 0; i < MaxNodes; i++) begin
      pr_deg[i] = '0;
      pr_rank[i] = '0;
      pr_acc[i] = '0;
    end
  end

  function automatic int unsigned nodes_used();
    int unsigned n;
    n = pr_count;
    if (n < 2) n = 2;
    if (n > MaxNodes) n = MaxNodes;
    return n;
  endfunction

  function automatic int unsigned run_cost();
    return (pr_iters + 1) * (pr_ecnt * 70 + nodes_used() * 72) + 1300;
  endfunction

  task automatic propagate_ranks();
    int unsigned n;
    logic [63:0] lo, hi, v, sum;
    logic [95:0] q;
    n = nodes_used();
    lo = 64'h1_0000_0000 / (n * n);
    if (lo == 0) lo = 1;
    hi = 64'h1_0000_0000 - lo;
    for (int i = 0; i < MaxNodes; i++) begin
      pr_rank[i] = (i < n) ? RankW'(64'h1_0000_0000 / n) : '0;
      pr_acc[i] = '0;
    end
    for (int it = 0; it < pr_iters; it++) begin
      for (int e = 0; e < pr_ecnt; e++) begin
        if (pr_esrc[e] >= n || pr_edst[e] >= n || pr_deg[pr_esrc[e]] == 0) continue;
        v = 64'(pr_acc[pr_edst[e]]) + 64'(pr_rank[pr_esrc[e]]) / 64'(pr_deg[pr_esrc[e]]);
        pr_acc[pr_edst[e]] = (v > AccMax) ? AccMax : v[AccW-1:0];
      end
      sum = 0;
      for (int i = 0; i < n; i++) begin
        v = pr_acc[i];
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        pr_acc[i] = v[AccW-1:0];
        sum += v;
      end
      for (int i = 0; i < n; i++) begin
        q = {31'b0, pr_acc[i], 32'b0} / {32'b0, sum};
        pr_rank[i] = (q > 96'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
        pr_acc[i] = '0;
      end
    end
  endtask

  task automatic predict_rank(input logic [1:0] m, input logic [NodeW-1:0] s,
                              input logic [NodeW-1:0] d, output rank_result_t r);
    int unsigned n;
    n = nodes_used();
    r.status = StatusOk;
    r.node = s;
    r.rank_value = '0;
    case (m)
      ModeLoad: begin
        if (s >= n || d >= n) r.status = StatusRange;
        else if (pr_ecnt >= MaxEdges) r.status = StatusFull;
        else begin
          pr_esrc[pr_ecnt] = s;
          pr_edst[pr_ecnt] = d;
          pr_ecnt++;
          pr_deg[s] = pr_deg[s] + 1'b1;
        end
      end
      ModeRun: propagate_ranks();
      ModeRead: begin
        if (s >= n) r.status = StatusRange;
        else r.rank_value = pr_rank[s];
      end
      default: begin
        pr_ecnt = 0;
        for (int i = 0; i < MaxNodes; i++) pr_deg[i] = '0;
      end
    endcase
  endtask

  task automatic send_request(input logic [1:0] m, input logic [NodeW-1:0] s,
                              input logic [NodeW-1:0] d);
    rank_result_t r;
    int unsigned gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    predict_rank(m, s, d, r);
    rank_expect_q.push_back(r);
    in_valid_i <= 1'b1;
    mode_i <= m;
    src_node_i <= s;
    dst_node_i <= d;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (rank_expect_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [CfgW-1:0] value);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgIterations) pr_iters = value[IterW-1:0];
    else pr_count = value;
  endtask

  task automatic random_phase(input logic [IterW-1:0] it, input logic [CfgW-1:0] cnt,
                              input int unsigned items);
    int unsigned n, pick;
    logic [1:0] m;
    logic [NodeW-1:0] s, d;
    write_reg(CfgIterations, CfgW'(it));
    write_reg(CfgNodeCount, cnt);
    n = nodes_used();
    send_request(ModeClear, NodeW'($urandom_range(0, 1023)), NodeW'($urandom_range(0, 1023)));
    for (int k = 0; k < items; k++) begin
      if (!quiet && $urandom_range(0, 49) == 0) drain_results();
      pick = $urandom_range(0, 99);
      s = NodeW'($urandom_range(0, n - 1));
      d = NodeW'($urandom_range(0, n - 1));
      if ($urandom_range(0, 9) == 0) s = NodeW'($urandom_range(0, 1023));
      if ($urandom_range(0, 9) == 0) d = NodeW'($urandom_range(0, 1023));
      if (pick < 55) m = ModeLoad;
      else if (pick < 85) m = ModeRead;
      else if (pick < 95) m = ModeRun;
      else m = ModeClear;
      if (m == ModeRun && run_cost() > RunCap) m = ModeRead;
      send_request(m, s, d);
    end
    if (run_cost() < 200000) send_request(ModeRun, s, d);
    for (int k = 0; k < 8; k++) send_request(ModeRead, NodeW'($urandom_range(0, n - 1)), d);
  endtask

  req_row_t dir_rows[] = '{
    '{ModeRead, 10'd0,    10'd0,    1'b1, StatusOk,    32'd0},
    '{ModeRead, 10'd1023, 10'd1023, 1'b1, StatusOk,    32'd0},
    '{ModeLoad, 10'd8,    10'd0,    1'b1, StatusRange, 32'd0},
    '{ModeLoad, 10'd0,    10'd1023, 1'b1, StatusRange, 32'd0},
    '{ModeLoad, 10'd0,    10'd1,    1'b1, StatusOk,    32'd0},
    '{ModeLoad, 10'd1,    10'd2,    1'b1, StatusOk,    32'd0},
    '{ModeLoad, 10'd2,    10'd0,    1'b1, StatusOk,    32'd0},
    '{ModeLoad, 10'd3,    10'd0,    1'b1, StatusOk,    32'd0},
    '{ModeLoad, 10'd7,    10'd7,    1'b1, StatusOk,    32'd0},
    '{ModeLoad, 10'd0,    10'd0,    1'b1, StatusOk,    32'd0},
    '{ModeRead, 10'd9,    10'd3,    1'b1, StatusRange, 32'd0},
    '{ModeRun,  10'd1023, 10'd1023, 1'b1, StatusOk,    32'd0},
    '{ModeRead, 10'd0,    10'd0,    1'b0, StatusOk,    32'd0},
    '{ModeRead, 10'd1,    10'd0,    1'b0, StatusOk,    32'd0},
    '{ModeRead, 10'd2,    10'd0,    1'b0, StatusOk,    32'd0},
    '{ModeRead, 10'd5,    10'd0,    1'b0, StatusOk,    32'd0},
    '{ModeRead, 10'd7,    10'd0,    1'b0, StatusOk,    32'd0},
    '{ModeClear, 10'd4,   10'd9,    1'b1, StatusOk,    32'd0},
    '{ModeRun,  10'd6,    10'd0,    1'b1, StatusOk,    32'd0},
    '{ModeRead, 10'd3,    10'd0,    1'b0, StatusOk,    32'd0},
    '{ModeRead, 10'd1023, 10'd0,    1'b1, StatusRange, 32'd0}
  };

  always @(posedge clk_i) begin
    if (quiet) out_stall_i <= 1'b0;
    else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else out_stall_i <= 1'b0;
  end

  always @(posedge clk_i) begin
    rank_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (rank_expect_q.size() == 0) begin
        $display("%0t: unexpected result status %0d node %0d rank %0h",
                 $time, status_o, node_o, rank_value_o);
        errors++;
      end else begin
        e = rank_expect_q.pop_front();
        if (status_o !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, status_o);
          errors++;
        end
        if (node_o !== e.node) begin
          $display("%0t: node expected %0d actual %0d", $time, e.node, node_o);
          errors++;
        end
        if (rank_value_o !== e.rank_value) begin
          $display("%0t: rank expected %0h actual %0h", $time, e.rank_value, rank_value_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("pagerank_iteration_engine test failed");
      $finish;
    end
  end

  initial begin
    rank_result_t r;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < dir_rows.size(); i++) begin
      if (i == SplitRow) begin
        write_reg(CfgIterations, 11'd3);
        write_reg(CfgNodeCount, 11'd8);
      end
      send_request(dir_rows[i].mode, dir_rows[i].src, dir_rows[i].dst);
      if (dir_rows[i].typed) begin
        r = rank_expect_q.pop_back();
        r.status = dir_rows[i].status;
        r.rank_value = dir_rows[i].rank_value;
        rank_expect_q.push_back(r);
      end
    end
    // fill the edge store, then overflow it
    write_reg(CfgNodeCount, 11'd16);
    for (int k = 0; k < MaxEdges; k++)
      send_request(ModeLoad, NodeW'($urandom_range(0, 15)), NodeW'($urandom_range(0, 15)));
    send_request(ModeLoad, 10'd15, 10'd15);
    send_request(ModeLoad, 10'd0, 10'd0);
    send_request(ModeLoad, 10'd16, 10'd0);
    send_request(ModeClear, 10'd0, 10'd0);
    random_phase(8'd1, 11'd2, 120);
    random_phase(8'd255, 11'd2, 60);
    random_phase(8'd0, 11'd5, 100);
    random_phase(8'd4, 11'd16, 150);
    random_phase(8'd3, 11'd1, 100);
    random_phase(8'd2, 11'd33, 150);
    random_phase(8'd1, 11'd1024, 100);
    random_phase(8'd1, 11'd2047, 60);
    random_phase(8'd0, 11'd0, 40);
    drain_results();
    quiet = 1'b1;
    random_phase(8'd2, 11'd12, 120);
    drain_results();
    repeat (40) @(posedge clk_i);
    if (errors == 0 && rank_expect_q.size() == 0) begin
      $display("pagerank_iteration_engine test passed");
    end else begin
      $display("pagerank_iteration_engine test failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/pie_pkg.sv
rtl/pie_div.sv
rtl/pagerank_iteration_engine.sv
rtl/pie_checker.sv
tb/sv/tb.sv
